### hdl/sw_tmr_pkg.sv
// Shared types and codes of the software timer bank.
// No dependencies; the queue, front, back, top level and testbench import this package.
package sw_tmr_pkg;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_STOP   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_EXPIRY = 3'd4,
    KIND_DONE   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RUNNING   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CREATE,
    BK_TICK,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        periodic;
    logic [31:0] timeout;
    logic [3:0]  idx;
    logic [31:0] token;
    logic [31:0] ms;
    logic        ms_nz;
  } cmd_t;

endpackage

### hdl/sw_tmr_if.sv
// Handshake interfaces of the timer bank: command, result and configuration.
// Depends on nothing.
interface sw_tmr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic        periodic;
  logic [31:0] timeout_ms;
  logic [3:0]  timer_index;
  logic [31:0] user_token;
  logic [31:0] tick_now;
  modport source (output valid, operation, periodic, timeout_ms, timer_index, user_token,
                  tick_now, input ready);
  modport sink (input valid, operation, periodic, timeout_ms, timer_index, user_token,
                tick_now, output ready);
endinterface

interface sw_tmr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  status;
  logic [3:0]  entry;
  logic [31:0] token_out;
  logic        last;
  modport source (output valid, kind, status, entry, token_out, last, input ready);
  modport sink (input valid, kind, status, entry, token_out, last, output ready);
endinterface

interface sw_tmr_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hdl/sw_tmr_fifo.sv
// Two-entry command queue between the front and back of the timer bank.
// Depends on sw_tmr_pkg for the command word type.
module sw_tmr_fifo
  import sw_tmr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/sw_tmr_front.sv
// Front end: accepts commands, turns tick counts into elapsed milliseconds
// and queues known operations. Depends on sw_tmr_pkg and the interfaces.
module sw_tmr_front
  import sw_tmr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sw_tmr_in_if.sink    in_if,
  sw_tmr_cfg_if.sink   cfg_if,
  input  logic         q_full,
  output logic         q_push,
  output cmd_t         q_data
);

  logic [9:0]  ms_per_tick_r;
  logic [31:0] prev_tick_r;
  logic [31:0] delta;
  logic [41:0] prod;
  logic        accept;
  logic        known;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;
  assign accept = in_if.valid && in_if.ready;
  assign delta  = in_if.tick_now - prev_tick_r;
  assign prod   = delta * ms_per_tick_r;

  always_comb begin
    unique case (in_if.operation) inside
      OP_CREATE, OP_DELETE, OP_START, OP_STOP, OP_TICK: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign q_push = accept && known;
  always_comb begin
    q_data.op       = in_if.operation;
    q_data.periodic = in_if.periodic;
    q_data.timeout  = in_if.timeout_ms;
    q_data.idx      = in_if.timer_index;
    q_data.token    = in_if.user_token;
    q_data.ms       = prod[31:0];
    q_data.ms_nz    = delta != 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_per_tick_r <= 10'd1;
      prev_tick_r   <= 32'd0;
    end else begin
      if (cfg_if.valid) ms_per_tick_r <= cfg_if.data;
      if (accept && in_if.operation == OP_TICK) prev_tick_r <= in_if.tick_now;
    end
  end

endmodule

### hdl/sw_tmr_back.sv
// Back end: holds the timer entries, executes queued commands and scans
// entries for create and tick. Depends on sw_tmr_pkg and the interfaces.
module sw_tmr_back
  import sw_tmr_pkg::*;
#(
  parameter int TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_head,
  output logic          q_pop,
  sw_tmr_out_if.source  out_if
);

  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  bk_state_t   state_r, state_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt, addr;
  cmd_t        cmd_r;

  logic [TIMERS-1:0] alloc_r, run_r;
  logic [31:0] rem_r [TIMERS];
  logic [31:0] rel_r [TIMERS];
  logic [31:0] tok_r [TIMERS];

  logic        out_valid_r;
  kind_t       kind_r;
  status_t     status_r;
  logic [3:0]  entry_r;
  logic [31:0] token_r;
  logic        last_r;

  logic        can_emit, emit, step, finish, ptr_last, idx_ok;
  kind_t       e_kind;
  status_t     e_status;
  logic [3:0]  e_entry;
  logic [31:0] e_token;
  logic        e_last;
  logic        w_en, n_alloc, n_run;
  logic [31:0] n_rem, n_rel, n_tok, sub;
  logic        cur_alloc, cur_run;
  logic [31:0] cur_rem, cur_rel, cur_tok;

  assign can_emit = !out_valid_r || out_if.ready;
  assign ptr_last = ptr_r == IW'(TIMERS - 1);
  assign idx_ok   = 9'(q_head.idx) < 9'(TIMERS);
  assign addr     = (state_r == BK_IDLE) ? IW'(q_head.idx) : ptr_r;
  assign cur_alloc = alloc_r[addr];
  assign cur_run   = run_r[addr];
  assign cur_rem   = rem_r[addr];
  assign cur_rel   = rel_r[addr];
  assign cur_tok   = tok_r[addr];
  assign sub = (cur_rem > cmd_r.ms) ? cur_rem - cmd_r.ms : 32'd0;

  always_comb begin
    q_pop = 1'b0; step = 1'b0; finish = 1'b0; emit = 1'b0;
    e_kind = KIND_DONE; e_status = ST_OK; e_entry = 4'd0; e_token = 32'd0; e_last = 1'b1;
    w_en = 1'b0; n_alloc = cur_alloc; n_run = cur_run;
    n_rem = cur_rem; n_rel = cur_rel; n_tok = cur_tok;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && can_emit) begin
          q_pop   = 1'b1;
          e_entry = q_head.idx;
          case (q_head.op)
            OP_DELETE: begin
              emit = 1'b1; e_kind = KIND_DELETE;
              if (!(idx_ok && cur_alloc)) begin
                e_status = ST_NOT_ALLOC;
              end else begin
                w_en = 1'b1; n_alloc = 1'b0; n_run = 1'b0;
              end
            end
            OP_START: begin
              emit = 1'b1; e_kind = KIND_START;
              if (!(idx_ok && cur_alloc)) begin
                e_status = ST_NOT_ALLOC;
              end else if (cur_run) begin
                e_status = ST_RUNNING;
              end else begin
                w_en = 1'b1; n_run = 1'b1; n_tok = q_head.token;
                if (q_head.timeout != 32'd0) begin
                  n_rem = q_head.timeout;
                  if (cur_rel != 32'd0) n_rel = q_head.timeout;
                end
              end
            end
            OP_STOP: begin
              emit = 1'b1; e_kind = KIND_STOP;
              if (!(idx_ok && cur_alloc)) begin
                e_status = ST_NOT_ALLOC;
              end else begin
                w_en = 1'b1; n_run = 1'b0; e_token = cur_tok;
              end
            end
            default: ;
          endcase
        end
      end
      BK_CREATE: begin
        e_kind = KIND_CREATE;
        if (!cur_alloc) begin
          if (can_emit) begin
            emit = 1'b1; finish = 1'b1; e_entry = 4'(ptr_r);
            w_en = 1'b1; n_alloc = 1'b1; n_run = 1'b0; n_rem = cmd_r.timeout;
            n_rel = cmd_r.periodic ? cmd_r.timeout : 32'd0; n_tok = 32'd0;
          end
        end else if (ptr_last) begin
          if (can_emit) begin
            emit = 1'b1; finish = 1'b1; e_status = ST_NO_FREE;
          end
        end else begin
          step = 1'b1;
        end
      end
      BK_TICK: begin
        if (cur_alloc && cur_run) begin
          if (sub == 32'd0) begin
            if (can_emit) begin
              step = 1'b1; emit = 1'b1; e_kind = KIND_EXPIRY; e_entry = 4'(ptr_r);
              e_token = cur_tok; e_last = 1'b0; w_en = 1'b1;
              if (cur_rel != 32'd0) begin
                n_rem = cur_rel;
              end else begin
                n_rem = 32'd0; n_alloc = 1'b0; n_run = 1'b0;
              end
            end
          end else begin
            step = 1'b1; w_en = 1'b1; n_rem = sub;
          end
        end else begin
          step = 1'b1;
        end
      end
      BK_DONE: begin
        if (can_emit) begin
          emit = 1'b1; finish = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop && q_head.op == OP_CREATE) state_nxt = BK_CREATE;
        else if (q_pop && q_head.op == OP_TICK) state_nxt = q_head.ms_nz ? BK_TICK : BK_DONE;
      end
      BK_CREATE: if (finish) state_nxt = BK_IDLE;
      BK_TICK:   if (step && ptr_last) state_nxt = BK_DONE;
      BK_DONE:   if (finish) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  assign ptr_nxt = (state_r == BK_IDLE) ? '0 : (step ? ptr_r + 1'b1 : ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      alloc_r     <= '0;
      run_r       <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      if (can_emit) out_valid_r <= emit;
      if (w_en) begin
        alloc_r[addr] <= n_alloc;
        run_r[addr]   <= n_run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMERS; i++) begin
        rem_r[i] <= 32'd0;
        rel_r[i] <= 32'd0;
        tok_r[i] <= 32'd0;
      end
    end else if (w_en) begin
      rem_r[addr] <= n_rem;
      rel_r[addr] <= n_rel;
      tok_r[addr] <= n_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_head;
    if (emit) begin
      kind_r   <= e_kind;
      status_r <= e_status;
      entry_r  <= e_entry;
      token_r  <= e_token;
      last_r   <= e_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.kind      = kind_r;
  assign out_if.status    = status_r;
  assign out_if.entry     = entry_r;
  assign out_if.token_out = token_r;
  assign out_if.last      = last_r;

  a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_TICK |-> cmd_r.ms_nz) else $error("tick scan without elapsed time");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == BK_IDLE && !q_empty) else $error("queue popped while busy");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_DONE) |-> last_r) else $error("tick done without last");

endmodule

### hdl/software_timer_bank.sv
// Top level of the software timer bank: front end, command queue and back end.
// Depends on sw_tmr_pkg, the interfaces, sw_tmr_front, sw_tmr_fifo, sw_tmr_back.
//
//   channel  direction  word
//   in_if    sink       operation, periodic, timeout_ms, timer_index, user_token, tick_now
//   out_if   source     kind, status, entry, token_out, last
//   cfg_if   sink       ms_per_tick
//
// Delete, start and stop are executed as they are popped. Create pops and then scans
// entries from the lowest, one per cycle, until it finds a free one or passes the last.
// Tick pops, visits every entry once, one per cycle, then emits done; when no time
// elapsed it goes straight to done. A stalled output holds the scan while a word waits.
// A two-word queue lets the front accept while the back scans or the output stalls.
// Reset is synchronous and frees and stops every entry at once.
module software_timer_bank
  import sw_tmr_pkg::*;
#(
  parameter int TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  sw_tmr_in_if.sink     in_if,
  sw_tmr_out_if.source  out_if,
  sw_tmr_cfg_if.sink    cfg_if
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_data, q_head;

  sw_tmr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .cfg_if(cfg_if),
    .q_full(q_full), .q_push(q_push), .q_data(q_data)
  );

  sw_tmr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  sw_tmr_back #(.TIMERS(TIMERS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_if(out_if)
  );

endmodule

### test/testbench.sv
// Self-checking testbench of the software timer bank: directed and random commands.
// Depends on sw_tmr_pkg, the timer bank interfaces and software_timer_bank.
module testbench;
  import sw_tmr_pkg::*;

  localparam int NUM_TIMERS = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [3:0]  entry;
    logic [31:0] token;
    logic        last;
  } reply_t;

  logic clk = 0;
  logic rst_n = 0;

  sw_tmr_in_if  in_ch();
  sw_tmr_out_if out_ch();
  sw_tmr_cfg_if cfg_ch();

  software_timer_bank #(.TIMERS(NUM_TIMERS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  logic [31:0] tmr_left [NUM_TIMERS];
  logic [31:0] tmr_reload [NUM_TIMERS];
  logic [31:0] tmr_token [NUM_TIMERS];
  bit          tmr_used [NUM_TIMERS];
  bit          tmr_run [NUM_TIMERS];
  logic [31:0] last_tick;
  logic [9:0]  scale;

  reply_t replies_due[$];
  int     errors = 0;
  int     words_sent = 0;
  int     replies_seen = 0;
  int     expiries_seen = 0;
  int     send_pct = 0;
  int     recv_pct = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic void push_reply(kind_t k, status_t s, logic [3:0] e, logic [31:0] t,
                                     logic l);
    reply_t r;
    r.kind = k;
    r.status = s;
    r.entry = e;
    r.token = t;
    r.last = l;
    replies_due.push_back(r);
  endfunction

  // Updates the bank image for one accepted word and queues its replies.
  function automatic void apply_command(logic [2:0] op, logic per, logic [31:0] tmo,
                                        logic [3:0] idx, logic [31:0] tok, logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] ms;
    bit found;
    found = 0;
    case (op)
      OP_CREATE: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (!found && !tmr_used[i]) begin
            found = 1;
            tmr_used[i] = 1;
            tmr_run[i] = 0;
            tmr_left[i] = tmo;
            tmr_reload[i] = per ? tmo : 32'd0;
            tmr_token[i] = 0;
            push_reply(KIND_CREATE, ST_OK, i[3:0], 0, 1);
          end
        end
        if (!found) push_reply(KIND_CREATE, ST_NO_FREE, 0, 0, 1);
      end
      OP_DELETE: begin
        if (!tmr_used[idx]) begin
          push_reply(KIND_DELETE, ST_NOT_ALLOC, idx, 0, 1);
        end else begin
          tmr_used[idx] = 0;
          tmr_run[idx] = 0;
          push_reply(KIND_DELETE, ST_OK, idx, 0, 1);
        end
      end
      OP_START: begin
        if (!tmr_used[idx]) begin
          push_reply(KIND_START, ST_NOT_ALLOC, idx, 0, 1);
        end else if (tmr_run[idx]) begin
          push_reply(KIND_START, ST_RUNNING, idx, 0, 1);
        end else begin
          if (tmo != 0) begin
            tmr_left[idx] = tmo;
            if (tmr_reload[idx] != 0) tmr_reload[idx] = tmo;
          end
          tmr_token[idx] = tok;
          tmr_run[idx] = 1;
          push_reply(KIND_START, ST_OK, idx, 0, 1);
        end
      end
      OP_STOP: begin
        if (!tmr_used[idx]) begin
          push_reply(KIND_STOP, ST_NOT_ALLOC, idx, 0, 1);
        end else begin
          tmr_run[idx] = 0;
          push_reply(KIND_STOP, ST_OK, idx, tmr_token[idx], 1);
        end
      end
      OP_TICK: begin
        elapsed = now - last_tick;
        last_tick = now;
        if (elapsed != 0) begin
          ms = elapsed * {22'd0, scale};
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr_used[i] && tmr_run[i]) begin
              tmr_left[i] = (tmr_left[i] > ms) ? tmr_left[i] - ms : 32'd0;
              if (tmr_left[i] == 0) begin
                push_reply(KIND_EXPIRY, ST_OK, i[3:0], tmr_token[i], 0);
                if (tmr_reload[i] != 0) begin
                  tmr_left[i] = tmr_reload[i];
                end else begin
                  tmr_used[i] = 0;
                  tmr_run[i] = 0;
                end
              end
            end
          end
        end
        push_reply(KIND_DONE, ST_OK, 0, 0, 1);
      end
      default: ;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (out_ch.valid && out_ch.ready) begin
      replies_seen++;
      if (out_ch.kind == KIND_EXPIRY) expiries_seen++;
      if (replies_due.size() == 0) begin
        $error("unexpected reply word: kind %0d entry %0d", out_ch.kind, out_ch.entry);
        errors++;
      end else begin
        e = replies_due.pop_front();
        if (out_ch.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          errors++;
        end
        if (out_ch.entry !== e.entry) begin
          $error("entry: expected %0d, got %0d", e.entry, out_ch.entry);
          errors++;
        end
        if (out_ch.token_out !== e.token) begin
          $error("token_out: expected %h, got %h", e.token, out_ch.token_out);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out with %0d replies outstanding.", replies_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(logic [2:0] op, logic per, logic [31:0] tmo, logic [3:0] idx,
                           logic [31:0] tok, logic [31:0] now);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.periodic <= per;
    in_ch.timeout_ms <= tmo;
    in_ch.timer_index <= idx;
    in_ch.user_token <= tok;
    in_ch.tick_now <= now;
    do @(posedge clk); while (!in_ch.ready);
    apply_command(op, per, tmo, idx, tok, now);
    words_sent++;
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_scale(logic [9:0] v);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    scale = v;
  endtask

  function automatic logic [3:0] pick_entry();
    int used[$];
    for (int i = 0; i < NUM_TIMERS; i++) if (tmr_used[i]) used.push_back(i);
    if (used.size() == 0 || $urandom_range(99) < 30) return 4'($urandom_range(0, 15));
    return 4'(used[$urandom_range(0, used.size() - 1)]);
  endfunction

  task automatic test_commands;
    send_word(OP_CREATE, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_word(OP_CREATE, 1, 0, 0, 0, 0);
    send_word(OP_CREATE, 1, 5, 0, 0, 0);
    send_word(OP_START, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_word(OP_START, 0, 7, 0, 32'h1234_5678, 0);
    send_word(OP_START, 0, 0, 1, 32'hA5A5_5A5A, 0);
    send_word(OP_START, 0, 10, 2, 32'h0000_0001, 0);
    send_word(OP_TICK, 0, 0, 0, 0, 3);
    send_word(OP_TICK, 0, 0, 0, 0, 3);
    send_word(OP_TICK, 0, 0, 0, 0, 13);
    send_word(OP_STOP, 0, 0, 0, 0, 0);
    send_word(OP_STOP, 0, 0, 9, 0, 0);
    send_word(OP_DELETE, 0, 0, 0, 0, 0);
    send_word(OP_DELETE, 0, 0, 0, 0, 0);
    send_word(3'd5, 1, 32'hFFFF_FFFF, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(3'd7, 0, 0, 0, 0, 0);
    send_word(OP_DELETE, 0, 0, 2, 0, 0);
    send_word(OP_START, 0, 1, 15, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFF0);
    send_word(OP_TICK, 0, 0, 0, 0, 32'h0000_0005);
    drain();
  endtask

  task automatic test_full_bank;
    for (int i = 0; i <= NUM_TIMERS; i++) send_word(OP_CREATE, i[0], i + 1, 0, 0, 0);
    for (int i = 0; i < NUM_TIMERS; i++) send_word(OP_START, 0, 0, i[3:0], $urandom, 0);
    send_word(OP_TICK, 0, 0, 0, 0, last_tick + 20);
    for (int i = 0; i < NUM_TIMERS; i++) send_word(OP_DELETE, 0, 0, i[3:0], 0, 0);
    drain();
  endtask

  task automatic test_scale_extremes;
    set_scale(10'd0);
    send_word(OP_CREATE, 0, 0, 0, 0, 0);
    send_word(OP_CREATE, 0, 9, 0, 0, 0);
    send_word(OP_START, 0, 0, 0, 32'hDEAD_BEEF, 0);
    send_word(OP_START, 0, 0, 1, 32'hFEED_F00D, 0);
    send_word(OP_TICK, 0, 0, 0, 0, last_tick + 1000);
    set_scale(10'd1023);
    send_word(OP_TICK, 0, 0, 0, 0, last_tick + 32'h0040_1000);
    send_word(OP_DELETE, 0, 0, 1, 0, 0);
    drain();
  endtask

  task automatic test_backpressure;
    send_pct = 0;
    recv_pct = 0;
    @(posedge clk);
    hold_left <= 400;
    for (int i = 0; i < 12; i++) send_word(OP_CREATE, 1'($urandom_range(0, 1)), 50, 0, 0, 0);
    for (int i = 0; i < 12; i++) send_word(OP_START, 0, 0, i[3:0], $urandom, 0);
    send_word(OP_TICK, 0, 0, 0, 0, last_tick + 60);
    drain();
    for (int i = 0; i < NUM_TIMERS; i++) send_word(OP_DELETE, 0, 0, i[3:0], 0, 0);
    drain();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    int pick;
    logic [31:0] tmo;
    send_pct = s_pct;
    recv_pct = r_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      tmo = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 3000);
      if (pick < 22) begin
        send_word(OP_CREATE, 1'($urandom_range(0, 1)), tmo, 4'($urandom), $urandom,
                  $urandom);
      end else if (pick < 50) begin
        send_word(OP_START, 1'($urandom), tmo, pick_entry(), $urandom, $urandom);
      end else if (pick < 60) begin
        send_word(OP_STOP, 1'($urandom), $urandom, pick_entry(), $urandom, $urandom);
      end else if (pick < 70) begin
        send_word(OP_DELETE, 1'($urandom), $urandom, pick_entry(), $urandom, $urandom);
      end else if (pick < 96) begin
        send_word(OP_TICK, 1'($urandom), $urandom, 4'($urandom),
                  $urandom, ($urandom_range(9) == 0) ? $urandom :
                  last_tick + $urandom_range(0, 30));
      end else begin
        send_word(3'($urandom_range(5, 7)), 1'($urandom), $urandom, 4'($urandom), $urandom,
                  $urandom);
      end
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.operation = OP_CREATE;
    in_ch.periodic = 0;
    in_ch.timeout_ms = 0;
    in_ch.timer_index = 0;
    in_ch.user_token = 0;
    in_ch.tick_now = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    last_tick = 0;
    scale = 10'd1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_left[i] = 0;
      tmr_reload[i] = 0;
      tmr_token[i] = 0;
      tmr_used[i] = 0;
      tmr_run[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_commands();
    test_full_bank();
    test_scale_extremes();
    set_scale(10'd1);
    test_backpressure();
    test_random(12, 0, 0);
    set_scale(10'd1000);
    test_random(12, 50, 0);
    set_scale(10'd1);
    test_random(12, 0, 50);
    set_scale(10'($urandom_range(1, 20)));
    test_random(12, 12, 12);
    drain();

    $display("Sent %0d command words and checked %0d reply words, %0d of them expiries.",
             words_sent, replies_seen, expiries_seen);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
